// ===== rtl/core/olad_pkg.sv =====
// Shared types and codes for the ordered list append/delete unit.
package olad_pkg;

  localparam int EntryCountBits = 5;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_DELETE = 1'b1
  } olad_func_t;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } olad_status_t;

  typedef struct packed {
    olad_func_t         func;
    logic signed [31:0] value;
  } olad_cmd_t;

  typedef struct packed {
    olad_status_t              status;
    logic [EntryCountBits-1:0] entry_count;
  } olad_rsp_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic capture;  // latch compare result against key
    logic append;   // first free cell takes key
    logic remove;   // cells at or after the first match take right neighbor
  } olad_cell_ctl_t;

endpackage

// ===== rtl/core/olad_cell.sv =====
// One list cell: holds a value and its valid bit, takes the key on append, shifts left on delete.
module olad_cell import olad_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  olad_cell_ctl_t        ctl,
  input  logic [VALUE_BITS-1:0] key,
  input  logic                  prev_valid,
  input  logic                  next_valid,
  input  logic [VALUE_BITS-1:0] next_value,
  input  logic                  hit_in,
  output logic                  hit_out,
  output logic                  valid,
  output logic [VALUE_BITS-1:0] value
);

  logic match;
  logic take_append;
  logic take_shift;

  // hit ripples from head to tail; once set, every later cell shifts
  assign hit_out     = hit_in | match;
  assign take_append = ctl.append & prev_valid & ~valid;
  assign take_shift  = ctl.remove & hit_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match <= valid && (value == key);
      end
      if (take_append) begin
        valid <= 1'b1;
      end else if (take_shift) begin
        valid <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_append) begin
      value <= key;
    end else if (take_shift) begin
      value <= next_value;
    end
  end

endmodule

// ===== rtl/core/ordered_list_append_delete_unit.sv =====
// Top level: ordered list of cells with append-at-tail and delete-first-match.
// The accepting edge captures the compare; the update cycle then shifts/appends and pulses done.
// A new command is not accepted while busy; busy is high during the update cycle.
// All cells compare in parallel; the first-match flag ripples along the cell chain.
// Reset clears every valid bit and the count; the receiver cannot stall results.
module ordered_list_append_delete_unit import olad_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  olad_cmd_t cmd,
  output logic      busy,
  output logic      done,
  output olad_rsp_t rsp
);

  localparam int CountBits = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state;
  olad_func_t            func_q;
  logic [VALUE_BITS-1:0] key_q;
  logic [CountBits-1:0]  count;
  logic [CountBits-1:0]  count_next;
  olad_status_t          status_next;

  logic                  accept;
  logic [VALUE_BITS-1:0] key;
  olad_cell_ctl_t        ctl;

  logic [CAPACITY-1:0]   cell_valid;
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY:0]     hit;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;
  assign key    = busy ? key_q : VALUE_BITS'(cmd.value);

  assign ctl.capture = accept;
  assign ctl.append  = busy && (func_q == FUNC_APPEND);
  assign ctl.remove  = busy && (func_q == FUNC_DELETE);

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  prev_v;
    logic                  next_v;
    logic [VALUE_BITS-1:0] next_d;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_body
      assign next_v = cell_valid[i+1];
      assign next_d = cell_value[i+1];
    end
    olad_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_value (next_d),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .valid      (cell_valid[i]),
      .value      (cell_value[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_APPENDED;
    case (func_q)
      FUNC_APPEND: begin
        if (cell_valid[CAPACITY-1]) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_APPENDED;
          count_next  = count + CountBits'(1);
        end
      end
      FUNC_DELETE: begin
        if (!cell_valid[0]) begin
          status_next = ST_EMPTY;
        end else if (!hit[CAPACITY]) begin
          status_next = ST_NOT_FOUND;
        end else begin
          status_next = ST_DELETED;
          count_next  = count - CountBits'(1);
        end
      end
      default: begin
        status_next = ST_APPENDED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          count <= count_next;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= cmd.func;
      key_q  <= VALUE_BITS'(cmd.value);
    end
    if (busy) begin
      rsp.status      <= status_next;
      rsp.entry_count <= EntryCountBits'(count_next);
    end
  end

  // valid bits form a thermometer whose length is the count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("valid bits disagree with entry count");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an update cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("update cycle did not complete in one cycle");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] == (count != '0))
    else $error("head cell valid disagrees with count");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the ordered list append/delete unit.
module testbench;
  import olad_pkg::*;

  localparam int Capacity = 16;
  localparam int ValueBits = 32;
  localparam int RandomItems = 1925;
  localparam int CycleLimit = 250000;

  // Mirrors the list contents and queues the response each command must produce.
  class list_scoreboard;
    logic signed [31:0] held[$];
    olad_rsp_t pending_rsp[$];
    int errors;
    int status_seen[5];

    function void note_cmd(olad_cmd_t c);
      olad_rsp_t e;
      int hit;
      hit = -1;
      if (c.func == FUNC_APPEND) begin
        if (held.size() >= Capacity) begin
          e.status = ST_FULL;
        end else begin
          held.push_back(c.value);
          e.status = ST_APPENDED;
        end
      end else if (held.size() == 0) begin
        e.status = ST_EMPTY;
      end else begin
        // first match from the head wins
        foreach (held[i]) begin
          if (hit < 0 && held[i] == c.value) hit = i;
        end
        if (hit < 0) begin
          e.status = ST_NOT_FOUND;
        end else begin
          held.delete(hit);
          e.status = ST_DELETED;
        end
      end
      e.entry_count = EntryCountBits'(held.size());
      status_seen[e.status]++;
      pending_rsp.push_back(e);
    endfunction

    function void check_rsp(olad_rsp_t r);
      olad_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, got status %0d count %0d",
                 $time, r.status, r.entry_count);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (r.status !== e.status) begin
          $display("%0t: status mismatch, expected %0d got %0d", $time, e.status, r.status);
          errors++;
        end
        if (r.entry_count !== e.entry_count) begin
          $display("%0t: entry_count mismatch, expected %0d got %0d",
                   $time, e.entry_count, r.entry_count);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  olad_cmd_t cmd = '0;
  logic busy;
  logic done;
  olad_rsp_t rsp;
  int cycle_count = 0;
  list_scoreboard sb = new;

  ordered_list_append_delete_unit #(
    .CAPACITY  (Capacity),
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Edge-sampled monitor: sees pre-edge values of start, busy and done.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_cmd(cmd);
      if (done) sb.check_rsp(rsp);
    end
  end

  // Holds the command until the unit takes it; returns on the accepting edge.
  task automatic issue(input olad_func_t f, input logic signed [31:0] v);
    start <= 1'b1;
    cmd <= '{func: f, value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Few distinct values so duplicates and delete hits are common.
  function automatic logic signed [31:0] pool_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return 32'sd42;
      6: return -32'sd42;
      default: return 32'sh5555_aaaa;
    endcase
  endfunction

  initial begin
    int n;
    int k;
    int seg_len;
    int append_pct;
    bit quiet;
    olad_func_t f;
    logic signed [31:0] v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, extremes, duplicates, misses, head/middle/tail, full.
    issue(FUNC_DELETE, 32'sd3);
    issue(FUNC_APPEND, 32'sh8000_0000);
    issue(FUNC_APPEND, 32'sh7fff_ffff);
    issue(FUNC_APPEND, 32'sd0);
    issue(FUNC_APPEND, -32'sd1);
    issue(FUNC_APPEND, 32'sd7);
    issue(FUNC_APPEND, 32'sd7);
    issue(FUNC_APPEND, 32'sd7);
    issue(FUNC_DELETE, 32'sd7);
    issue(FUNC_DELETE, 32'sd5);
    issue(FUNC_DELETE, 32'sh8000_0000);
    for (k = 0; k < 11; k++) issue(FUNC_APPEND, 32'sd100 + k);
    issue(FUNC_APPEND, 32'sd999);
    issue(FUNC_DELETE, 32'sd110);
    issue(FUNC_DELETE, -32'sd1);
    issue(FUNC_DELETE, 32'sh7fff_ffff);
    hold_off(3);

    n = 0;
    while (n < RandomItems) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: append_pct = 15;
        1: append_pct = 50;
        default: append_pct = 85;
      endcase
      quiet = ($urandom_range(0, 3) == 0) || (n > RandomItems * 4 / 5);
      for (k = 0; k < seg_len && n < RandomItems; k++) begin
        if ($urandom_range(0, 99) < append_pct) begin
          f = FUNC_APPEND;
          v = ($urandom_range(0, 1) == 0) ? pool_value() : $urandom;
        end else begin
          f = FUNC_DELETE;
          case ($urandom_range(0, 5))
            0, 1, 2: v = (sb.held.size() > 0) ?
                         sb.held[$urandom_range(0, sb.held.size() - 1)] : pool_value();
            3, 4: v = pool_value();
            default: v = $urandom;
          endcase
        end
        issue(f, v);
        n++;
        if (!quiet && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 16));
      end
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Covered %0d commands: appended %0d, deleted %0d, not found %0d,",
             RandomItems + 26, sb.status_seen[ST_APPENDED], sb.status_seen[ST_DELETED],
             sb.status_seen[ST_NOT_FOUND]);
    $display("empty %0d, full %0d; %0d field mismatches",
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL], sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/olad_pkg.sv
rtl/core/olad_cell.sv
rtl/core/ordered_list_append_delete_unit.sv
tb/sv/testbench.sv
